[sv/scan_nearest_resampler_defines.svh]
// Assertion helpers shared by the resampler RTL.
// All of them sample on clk and are quiet while rst_n is low.
`ifndef SCAN_NEAREST_RESAMPLER_DEFINES_SVH
`define SCAN_NEAREST_RESAMPLER_DEFINES_SVH

// Condition that must hold at every clock edge
`define SNR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SNR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define SNR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/snr_pkg.sv]
`default_nettype none

package snr_pkg;

    // Field and register widths
    localparam int MODE_W    = 2;
    localparam int WORD_W    = 32;
    localparam int TGT_W     = 13;
    localparam int SPAN_W    = 23;
    localparam int STEP_W    = 20;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 2;

    // Index arithmetic: k*span product, (tgt-1)*step product
    localparam int PROD_W = TGT_W + SPAN_W;
    localparam int DENP_W = TGT_W + STEP_W;
    // Dividend 2*k*span + den, divisor 2*den
    localparam int NUM_W  = PROD_W + 2;
    localparam int DEN_W  = DENP_W + 1;
    localparam int DIV_CNT_W = 6;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_STORE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PULL  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 2'd2;

    // Register reset values
    localparam logic [TGT_W-1:0]  TARGET_RESET = 13'd450;
    localparam logic [SPAN_W-1:0] SPAN_RESET   = 23'd6588397;
    localparam logic [STEP_W-1:0] STEP_RESET   = 20'd14641;

    // +inf single-precision word for an empty scan
    localparam logic [WORD_W-1:0] INF_BITS = 32'h7F80_0000;

    // One stored point
    typedef struct packed {
        logic [WORD_W-1:0] range_word;
        logic [WORD_W-1:0] intensity_word;
    } point_t;

endpackage

`default_nettype wire

[sv/scan_nearest_resampler.sv]
// Channel   Handshake           Payload
// ------    ------------------  ---------------------------------------------------
// item in   start & !busy       mode, range_bits, intensity_bits, has_intensity
// result    strobe (1 cycle)    out_range_bits, out_intensity_bits,
//                               out_has_intensity, last_point
// config    wr_en               wr_index, wr_data
//
// Store, close and ignored items finish at the accepting edge; busy stays low.
// A pull that needs the index division raises strobe after the multiplies, the divider
// load, 38 divider steps, taking the quotient, the point store read and the result
// registers. A direct pull (count equals target, target of one) skips the division and
// starts at the store read; an empty scan goes straight to the result registers.
// Busy is high from the accepting edge until the strobe edge.
// Reset is asynchronous, active low; the point store needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
`include "scan_nearest_resampler_defines.svh"

module scan_nearest_resampler #(
    parameter int MAX_POINTS = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // item in
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [snr_pkg::MODE_W-1:0]        mode,
    input  wire logic [snr_pkg::WORD_W-1:0]        range_bits,
    input  wire logic [snr_pkg::WORD_W-1:0]        intensity_bits,
    input  wire logic                              has_intensity,
    // result
    output logic                                   strobe,
    output logic [snr_pkg::WORD_W-1:0]             out_range_bits,
    output logic [snr_pkg::WORD_W-1:0]             out_intensity_bits,
    output logic                                   out_has_intensity,
    output logic                                   last_point,
    // config
    input  wire logic                              wr_en,
    input  wire logic [snr_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [snr_pkg::CFG_W-1:0]         wr_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam int TGT_W  = snr_pkg::TGT_W;
    localparam int SPAN_W = snr_pkg::SPAN_W;
    localparam int STEP_W = snr_pkg::STEP_W;
    localparam int PROD_W = snr_pkg::PROD_W;
    localparam int DENP_W = snr_pkg::DENP_W;
    localparam int NUM_W  = snr_pkg::NUM_W;
    localparam int DEN_W  = snr_pkg::DEN_W;
    localparam int WORD_W = snr_pkg::WORD_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_PREP = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_READ = 7'b0010000,
        S_DATA = 7'b0100000,
        S_HOLD = 7'b1000000
    } state_t;

    // Configuration
    logic [TGT_W-1:0]  target_count_reg;
    logic [SPAN_W-1:0] angle_span_reg;
    logic [STEP_W-1:0] in_angle_step_reg;

    // Scan state
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              closed_reg, closed_next;
    logic              iflag_reg, iflag_next;
    logic [AW-1:0]     oidx_reg, oidx_next;

    // Pull working registers
    logic [AW-1:0]     k_reg, k_next;
    logic [CW-1:0]     tgt_reg, tgt_next;
    logic              empty_reg, empty_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [DENP_W-1:0] denp_reg, denp_next;

    // Result registers
    logic              strobe_reg, strobe_next;
    logic [WORD_W-1:0] range_out_reg, range_out_next;
    logic [WORD_W-1:0] inten_out_reg, inten_out_next;
    logic              hasi_out_reg, hasi_out_next;
    logic              last_out_reg, last_out_next;

    // Store and divider hookup
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    snr_pkg::point_t   mem_wpoint;
    snr_pkg::point_t   mem_rpoint;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;

    logic              accept;
    logic [CW-1:0]     cnt_base;
    logic [CW-1:0]     tgt_eff;
    logic [CW-1:0]     k_cur;
    logic [STEP_W-1:0] step_eff;
    logic [TGT_W-1:0]  k_wide;
    logic [TGT_W-1:0]  tgt_less;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Effective target: zero acts as one, capped at the store depth
    always_comb
    begin
        if (target_count_reg == '0)
        begin
            tgt_eff = CW'(1);
        end
        else if (32'(target_count_reg) > 32'(MAX_POINTS))
        begin
            tgt_eff = CW'(MAX_POINTS);
        end
        else
        begin
            tgt_eff = CW'(target_count_reg);
        end
    end

    assign k_cur    = (CW'(oidx_reg) >= tgt_eff) ? '0 : CW'(oidx_reg);
    assign step_eff = (in_angle_step_reg == '0) ? STEP_W'(1) : in_angle_step_reg;
    assign k_wide   = TGT_W'(k_reg);
    assign tgt_less = TGT_W'(tgt_reg - CW'(1));
    assign cnt_base = closed_reg ? '0 : count_reg;

    // Divider operands: 2*k*span + den over 2*den
    assign div_start = (state_reg == S_PREP);
    assign div_num   = NUM_W'({prod_reg, 1'b0}) + NUM_W'(denp_reg);
    assign div_den   = {denp_reg, 1'b0};

    // Store write on an accepted store item
    assign mem_waddr  = cnt_base[AW-1:0];
    assign mem_wpoint = '{range_word: range_bits, intensity_word: intensity_bits};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        closed_next    = closed_reg;
        iflag_next     = iflag_reg;
        oidx_next      = oidx_reg;
        k_next         = k_reg;
        tgt_next       = tgt_reg;
        empty_next     = empty_reg;
        addr_next      = addr_reg;
        prod_next      = prod_reg;
        denp_next      = denp_reg;
        strobe_next    = 1'b0;
        range_out_next = range_out_reg;
        inten_out_next = inten_out_reg;
        hasi_out_next  = hasi_out_reg;
        last_out_next  = last_out_reg;
        mem_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        snr_pkg::MODE_STORE:
                        begin
                            // a store on a closed scan opens a new one
                            if (closed_reg)
                            begin
                                closed_next = 1'b0;
                                oidx_next   = '0;
                            end
                            count_next = cnt_base;
                            if (32'(cnt_base) < 32'(MAX_POINTS))
                            begin
                                mem_we     = 1'b1;
                                count_next = cnt_base + CW'(1);
                            end
                        end
                        snr_pkg::MODE_CLOSE:
                        begin
                            closed_next = 1'b1;
                            iflag_next  = has_intensity;
                            oidx_next   = '0;
                        end
                        snr_pkg::MODE_PULL:
                        begin
                            if (closed_reg)
                            begin
                                k_next    = AW'(k_cur);
                                tgt_next  = tgt_eff;
                                oidx_next = (k_cur + CW'(1) >= tgt_eff) ? '0
                                                                       : AW'(k_cur + CW'(1));
                                if (count_reg == '0)
                                begin
                                    empty_next = 1'b1;
                                    state_next = S_DATA;
                                end
                                else if (tgt_eff == count_reg)
                                begin
                                    empty_next = 1'b0;
                                    addr_next  = AW'(k_cur);
                                    state_next = S_READ;
                                end
                                else if (tgt_eff == CW'(1))
                                begin
                                    empty_next = 1'b0;
                                    addr_next  = '0;
                                    state_next = S_READ;
                                end
                                else
                                begin
                                    empty_next = 1'b0;
                                    state_next = S_MUL;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(k_wide) * PROD_W'(angle_span_reg);
                denp_next  = DENP_W'(tgt_less) * DENP_W'(step_eff);
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    // clamp to the last stored point
                    if (div_quo >= NUM_W'(count_reg))
                    begin
                        addr_next = AW'(count_reg - CW'(1));
                    end
                    else
                    begin
                        addr_next = div_quo[AW-1:0];
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                strobe_next    = 1'b1;
                range_out_next = empty_reg ? snr_pkg::INF_BITS : mem_rpoint.range_word;
                inten_out_next = (!empty_reg && iflag_reg) ? mem_rpoint.intensity_word
                                                           : '0;
                hasi_out_next  = iflag_reg;
                last_out_next  = (CW'(k_reg) == tgt_reg - CW'(1));
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            closed_reg        <= 1'b1;
            iflag_reg         <= 1'b0;
            oidx_reg          <= '0;
            strobe_reg        <= 1'b0;
            target_count_reg  <= snr_pkg::TARGET_RESET;
            angle_span_reg    <= snr_pkg::SPAN_RESET;
            in_angle_step_reg <= snr_pkg::STEP_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            iflag_reg  <= iflag_next;
            oidx_reg   <= oidx_next;
            strobe_reg <= strobe_next;
            if (wr_en)
            begin
                case (wr_index)
                    snr_pkg::REG_TARGET: target_count_reg  <= wr_data[TGT_W-1:0];
                    snr_pkg::REG_SPAN:   angle_span_reg    <= wr_data[SPAN_W-1:0];
                    snr_pkg::REG_STEP:   in_angle_step_reg <= wr_data[STEP_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        tgt_reg       <= tgt_next;
        empty_reg     <= empty_next;
        addr_reg      <= addr_next;
        prod_reg      <= prod_next;
        denp_reg      <= denp_next;
        range_out_reg <= range_out_next;
        inten_out_reg <= inten_out_next;
        hasi_out_reg  <= hasi_out_next;
        last_out_reg  <= last_out_next;
    end

    snr_store #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (AW)
    ) u_store (
        .clk      (clk),
        .wr_en    (mem_we),
        .wr_addr  (mem_waddr),
        .wr_point (mem_wpoint),
        .rd_addr  (addr_reg),
        .rd_point (mem_rpoint)
    );

    snr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign strobe             = strobe_reg;
    assign out_range_bits     = range_out_reg;
    assign out_intensity_bits = inten_out_reg;
    assign out_has_intensity  = hasi_out_reg;
    assign last_point         = last_out_reg;

    // Checks
    `SNR_ASSERT_NEXT(a_data_strobes, state_reg == S_DATA, strobe_reg && state_reg == S_IDLE,
        "result strobe missing after data stage")
    `SNR_ASSERT_SAME(a_strobe_source, strobe_reg, $past(state_reg == S_DATA),
        "result strobe without a data stage")
    `SNR_ASSERT_ALWAYS(a_count_bound, 32'(count_reg) <= 32'(MAX_POINTS),
        "point count beyond store depth")
    `SNR_ASSERT_SAME(a_read_in_scan, state_reg == S_READ, 32'(addr_reg) < 32'(count_reg),
        "store read beyond the stored points")
    `SNR_ASSERT_SAME(a_div_only_waiting, div_done, state_reg == S_DIV,
        "divider finished outside the divide stage")

endmodule

`default_nettype wire

[sv/snr_store.sv]
`default_nettype none

// Point store: one write port, one read port, registered read data
module snr_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire snr_pkg::point_t     wr_point,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output snr_pkg::point_t          rd_point
);

    snr_pkg::point_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_point;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_point <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[sv/snr_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle
module snr_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [snr_pkg::NUM_W-1:0]   num,
    input  wire logic [snr_pkg::DEN_W-1:0]   den,
    output logic                             done,
    output logic [snr_pkg::NUM_W-1:0]        quotient
);

    localparam int NW = snr_pkg::NUM_W;
    localparam int DW = snr_pkg::DEN_W;
    localparam int CW = snr_pkg::DIV_CNT_W;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    // One shift-subtract step; dividend bits shift out as quotient bits shift in
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        diff      = shifted - {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(NW - 1);
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (run_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
